@@ rtl/ppbs_pkg.sv @@
package ppbs_pkg;

	localparam int CELLS = 33;
	localparam logic [CELLS-1:0] SEED = 33'h05555554A;
	localparam logic [6:0] MAX_BURST = 7'd64;

	localparam logic [1:0] MODE_PRBS   = 2'd0;
	localparam logic [1:0] MODE_CYCLIC = 2'd1;
	localparam logic [1:0] MODE_ONCE   = 2'd2;

	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_ORDER   = 3'd1;
	localparam logic [2:0] REG_BUDGET  = 3'd2;
	localparam logic [2:0] REG_PATTERN = 3'd3;
	localparam logic [2:0] REG_SIZE    = 3'd4;

	typedef struct packed {
		logic adv;
		logic cyclic;
	} pat_ctl_t;

	// feedback taps on the shifted cells, per clamped order
	function automatic logic [CELLS-1:0] tap_mask(input logic [5:0] ord);
		logic [CELLS-1:0] m;
		case (ord)
			6'd1:  m = 33'h2;
			6'd2:  m = 33'h6;
			6'd3:  m = 33'hA;
			6'd4:  m = 33'h12;
			6'd5:  m = 33'h24;
			6'd6:  m = 33'h42;
			6'd7:  m = 33'h82;
			6'd8:  m = 33'h11C;
			6'd9:  m = 33'h210;
			6'd10: m = 33'h408;
			6'd11: m = 33'h804;
			6'd12: m = 33'h1052;
			6'd13: m = 33'h201A;
			6'd14: m = 33'h402A;
			6'd15: m = 33'h8002;
			6'd16: m = 33'h1002C;
			6'd17: m = 33'h20008;
			6'd18: m = 33'h40026;
			6'd19: m = 33'h80026;
			6'd20: m = 33'h100008;
			6'd21: m = 33'h200004;
			6'd22: m = 33'h400002;
			6'd23: m = 33'h800020;
			6'd24: m = 33'h100001A;
			6'd25: m = 33'h2000008;
			6'd26: m = 33'h4000046;
			6'd27: m = 33'h8000026;
			6'd28: m = 33'h10000008;
			6'd29: m = 33'h20000004;
			6'd30: m = 33'h40000054;
			6'd31: m = 33'h80000008;
			6'd32: m = 33'h1000000AE;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

@@ rtl/ppbs_lfsr.sv @@
module ppbs_lfsr
	import ppbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [5:0] order,
	output logic       gen_bit
);

	logic [CELLS-1:0] cells_q;
	logic [CELLS-1:0] shifted;
	logic [5:0]       ord_c;

	always_comb begin
		if (order == 6'd0) begin
			ord_c = 6'd1;
		end else if (order > 6'd32) begin
			ord_c = 6'd32;
		end else begin
			ord_c = order;
		end
	end

	assign gen_bit = cells_q[ord_c];

	// shift cells up to the order, leave the rest alone
	always_comb begin
		shifted[0] = cells_q[0];
		for (int i = 1; i < CELLS; i++) begin
			shifted[i] = (6'(i) <= ord_c) ? cells_q[i-1] : cells_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q <= SEED;
		end else if (adv) begin
			cells_q <= {shifted[CELLS-1:1], ^(shifted & tap_mask(ord_c))};
		end
	end

endmodule

@@ rtl/ppbs_pattern.sv @@
module ppbs_pattern
	import ppbs_pkg::*;
#(
	parameter int PATTERN_BITS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pat_ctl_t                ctl,
	input  logic [PATTERN_BITS-1:0] word,
	input  logic [6:0]              size,
	output logic                    pat_bit
);

	localparam int IW = (PATTERN_BITS > 1) ? $clog2(PATTERN_BITS) : 1;
	localparam logic [6:0] PB = 7'(PATTERN_BITS);

	logic [6:0] pos_q;
	logic [6:0] sz;
	logic [6:0] pos_eff;
	logic [6:0] pos_inc;
	logic [6:0] pos_nxt;
	logic       past_end;

	always_comb begin
		if (size == 7'd0) begin
			sz = 7'd1;
		end else if (size > PB) begin
			sz = PB;
		end else begin
			sz = size;
		end
	end

	assign past_end = (pos_q >= sz);
	assign pos_eff  = past_end ? 7'd0 : pos_q;
	assign pos_inc  = pos_eff + 7'd1;

	always_comb begin
		if (ctl.cyclic) begin
			pat_bit = word[pos_eff[IW-1:0]];
			pos_nxt = (pos_inc >= sz) ? 7'd0 : pos_inc;
		end else begin
			// played once: hold position and give zeros
			pat_bit = past_end ? 1'b0 : word[pos_eff[IW-1:0]];
			pos_nxt = past_end ? pos_q : pos_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctl.adv) begin
			pos_q <= pos_nxt;
		end
	end

endmodule

@@ rtl/prbs_pattern_bit_source_unit.sv @@
// Test-pattern bit source. Each input item asks for a burst of 1..64 bits and
// the block returns min(request, remaining budget) one-bit result items, one
// per clock while the output side takes them, with tlast on the final bit; a
// request of zero bits or a spent budget returns nothing. While a burst runs
// the input is held off: the request is taken, then the bit generator steps
// once per emitted bit, and each step waits while the previous bit sits
// untaken in the output register. The next request is taken once the final
// bit of the current burst sits in the output register. Configuration is a
// register write port (index 0 mode, 1 PRBS order, 2 bit budget, 3 pattern,
// 4 pattern size) that should be written only when the block is idle; a
// budget write reloads the remaining count, and a negative budget means no
// limit.
module prbs_pattern_bit_source_unit
	import ppbs_pkg::*;
#(
	parameter int PATTERN_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [6:0] bits_wanted
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] out_bit
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [1:0]              mode_q;
	logic [5:0]              order_q;
	logic [32:0]             budget_left_q;
	logic [PATTERN_BITS-1:0] pattern_q;
	logic [6:0]              size_q;

	logic       busy_q;
	logic       unl_q;
	logic [6:0] cnt_q;
	logic       m_tvalid_q;
	logic       out_bit_q;
	logic       last_q;

	logic       cfg_acc;
	logic       in_acc;
	logic       step;
	logic [6:0] want;
	logic [6:0] count;
	logic       lfsr_bit;
	logic       pat_bit;
	logic       gen_bit;
	pat_ctl_t   pat_ctl;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign s_tready  = ~busy_q;
	assign in_acc    = s_tvalid & s_tready;
	assign step      = busy_q & (~m_tvalid_q | m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, out_bit_q};
	assign m_tlast  = last_q;

	always_comb begin
		want = (s_tdata[6:0] > MAX_BURST) ? MAX_BURST : s_tdata[6:0];
		// cut to the budget when it is limited and smaller
		if (!budget_left_q[32] && budget_left_q[31:7] == '0 && budget_left_q[6:0] < want) begin
			count = budget_left_q[6:0];
		end else begin
			count = want;
		end
	end

	assign pat_ctl.adv    = step & (mode_q == MODE_CYCLIC | mode_q == MODE_ONCE);
	assign pat_ctl.cyclic = (mode_q == MODE_CYCLIC);

	ppbs_lfsr u_lfsr (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (step & (mode_q == MODE_PRBS)),
		.order   (order_q),
		.gen_bit (lfsr_bit)
	);

	ppbs_pattern #(
		.PATTERN_BITS (PATTERN_BITS)
	) u_pattern (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (pat_ctl),
		.word    (pattern_q),
		.size    (size_q),
		.pat_bit (pat_bit)
	);

	always_comb begin
		case (mode_q)
			MODE_PRBS:   gen_bit = lfsr_bit;
			MODE_CYCLIC: gen_bit = pat_bit;
			MODE_ONCE:   gen_bit = pat_bit;
			default:     gen_bit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PRBS;
			order_q <= 6'd31;
			size_q  <= 7'd1;
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[1:0];
				REG_ORDER: order_q <= cfg_data[5:0];
				REG_SIZE:  size_q  <= cfg_data[6:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
		end else if (cfg_acc && cfg_index == REG_PATTERN) begin
			pattern_q <= cfg_data[PATTERN_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_left_q <= '1;
		end else if (cfg_acc && cfg_index == REG_BUDGET) begin
			budget_left_q <= cfg_data[32:0];
		end else if (step && !unl_q) begin
			budget_left_q <= budget_left_q - 33'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			unl_q      <= 1'b0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			out_bit_q  <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= (count != 7'd0);
				unl_q  <= budget_left_q[32];
				cnt_q  <= count;
			end else if (step) begin
				busy_q <= (cnt_q != 7'd1);
				cnt_q  <= cnt_q - 7'd1;
			end
			if (step) begin
				m_tvalid_q <= 1'b1;
				out_bit_q  <= gen_bit;
				last_q     <= (cnt_q == 7'd1);
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
